// ----- rtl/cfdc_pkg.sv -----
package cfdc_pkg;

    localparam int unsigned MAX_PAYLOAD = 65535;

    localparam logic [16:0] HDR_LEN  = 17'd10;
    localparam logic [16:0] MAGIC_END = 17'd4;
    localparam logic [16:0] VER_POS  = 17'd4;
    localparam logic [16:0] TYPE_POS = 17'd5;
    localparam logic [16:0] POS_MAX  = 17'h1FFFF;
    localparam logic [33:0] CRC_LEN  = 34'd4;
    localparam logic [7:0]  TYPE_MIN = 8'd1;
    localparam logic [7:0]  TYPE_MAX = 8'd16;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] LEN_CAP  = 32'(MAX_PAYLOAD);

    localparam int unsigned Q_AW    = 2;
    localparam int unsigned Q_DEPTH = 1 << Q_AW;

    typedef enum logic [1:0] {
        CFG_MAGIC       = 2'd0,
        CFG_VERSION     = 2'd1,
        CFG_MAX_PAYLOAD = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_TYPE    = 3'd4,
        ST_LONG    = 3'd5,
        ST_SIZE    = 3'd6,
        ST_CRC     = 3'd7
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        t_status     status;
        logic [4:0]  msg_type;
        logic [15:0] payload_len;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// ----- rtl/cfdc_front.sv -----
module cfdc_front import cfdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  t_q_status   i_q_status,
    output logic        o_stall,
    output logic        o_push,
    output t_result     o_item
);

    logic [31:0] r_cfg_magic;
    logic [7:0]  r_cfg_version;
    logic [15:0] r_cfg_max;

    logic [16:0] r_pos, n_pos;
    logic [31:0] r_magic, n_magic;
    logic [7:0]  r_ver, n_ver;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_len, n_len;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_crcrx, n_crcrx;

    logic        w_accept;
    logic [32:0] w_end;
    logic        w_in_payload;
    logic        w_type_ok;
    t_status     w_status;

    assign o_stall  = i_q_status.full;
    assign w_accept = i_valid && !i_q_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_magic   <= 32'd0;
            r_cfg_version <= 8'd1;
            r_cfg_max     <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC:       r_cfg_magic   <= i_cfg_data;
                CFG_VERSION:     r_cfg_version <= i_cfg_data[7:0];
                CFG_MAX_PAYLOAD: r_cfg_max     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_magic = r_magic;
        n_ver   = r_ver;
        n_type  = r_type;
        n_len   = r_len;
        if (r_pos < MAGIC_END) begin
            n_magic = {i_data_byte, r_magic[31:8]};
        end else if (r_pos == VER_POS) begin
            n_ver = i_data_byte;
        end else if (r_pos == TYPE_POS) begin
            n_type = i_data_byte;
        end else if (r_pos < HDR_LEN) begin
            n_len = {i_data_byte, r_len[31:8]};
        end
        n_crcrx = {i_data_byte, r_crcrx[31:8]};

        w_end        = 33'(HDR_LEN) + {1'b0, n_len};
        w_in_payload = (r_pos >= HDR_LEN) && (33'(r_pos) < w_end);

        n_crc = r_crc;
        if (r_pos >= MAGIC_END && (r_pos < HDR_LEN || w_in_payload)) begin
            n_crc = crc_byte(r_crc, i_data_byte);
        end
        n_pos = (r_pos < POS_MAX) ? r_pos + 17'd1 : r_pos;

        w_type_ok = (n_type >= TYPE_MIN) && (n_type <= TYPE_MAX);

        if (n_pos < HDR_LEN) begin
            w_status = ST_SHORT;
        end else if (n_magic != r_cfg_magic) begin
            w_status = ST_MAGIC;
        end else if (n_ver != r_cfg_version) begin
            w_status = ST_VERSION;
        end else if (!w_type_ok) begin
            w_status = ST_TYPE;
        end else if (n_len > {16'd0, r_cfg_max} || n_len > LEN_CAP) begin
            w_status = ST_LONG;
        end else if (34'(n_pos) != 34'(w_end) + CRC_LEN) begin
            w_status = ST_SIZE;
        end else if (~n_crc != n_crcrx) begin
            w_status = ST_CRC;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        o_push = w_accept && (i_last_byte || w_in_payload);
        if (i_last_byte) begin
            o_item.kind        = KIND_VERDICT;
            o_item.out_byte    = 8'd0;
            o_item.status      = w_status;
            o_item.msg_type    = w_type_ok ? n_type[4:0] : 5'd0;
            o_item.payload_len = (n_len > 32'h0000FFFF) ? 16'hFFFF : n_len[15:0];
        end else begin
            o_item.kind        = KIND_PAYLOAD;
            o_item.out_byte    = i_data_byte;
            o_item.status      = ST_OK;
            o_item.msg_type    = 5'd0;
            o_item.payload_len = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_last_byte)) begin
            r_pos   <= 17'd0;
            r_magic <= 32'd0;
            r_ver   <= 8'd0;
            r_type  <= 8'd0;
            r_len   <= 32'd0;
            r_crc   <= 32'hFFFFFFFF;
            r_crcrx <= 32'd0;
        end else if (w_accept) begin
            r_pos   <= n_pos;
            r_magic <= n_magic;
            r_ver   <= n_ver;
            r_type  <= n_type;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_crcrx <= n_crcrx;
        end
    end

endmodule

// ----- rtl/cfdc_queue.sv -----
module cfdc_queue import cfdc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_item,
    input  logic      i_pop,
    output t_result   o_head,
    output t_q_status o_status
);

    t_result           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/cfdc_back.sv -----
module cfdc_back import cfdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_status   i_q_status,
    input  t_result     i_head,
    input  logic        i_stall,
    output logic        o_pop,
    output logic        o_valid,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic [4:0]  o_msg_type,
    output logic [15:0] o_payload_len
);

    logic    r_valid;
    t_result r_item;

    assign o_pop = !i_q_status.empty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_item.kind;
    assign o_out_byte    = r_item.out_byte;
    assign o_status      = r_item.status;
    assign o_msg_type    = r_item.msg_type;
    assign o_payload_len = r_item.payload_len;

endmodule

// ----- rtl/crc_frame_deframer_checker_unit.sv -----
// Frame deframer and checker: takes one received byte per cycle while o_stall is low, the
// final byte of a frame marked by i_last_byte, and returns each payload byte as an item of
// kind 0 and, on the final byte, one verdict item of kind 1 with the first failing check,
// the message type and the payload length from the header. Header fields and a byte-wide
// CRC-32 update are processed in the cycle a byte is accepted, so the block sustains one
// byte per clock unless stalled. A result enters a four-item queue when its byte is taken,
// then the output register when popped. The queue absorbs output stalls; o_stall = queue full.
module crc_frame_deframer_checker_unit import cfdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic [4:0]  o_msg_type,
    output logic [15:0] o_payload_len
);

    logic      w_push;
    logic      w_pop;
    t_result   w_item;
    t_result   w_head;
    t_q_status w_q_status;

    cfdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (w_q_status),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_item      (w_item)
    );

    cfdc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    cfdc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_status),
        .i_head        (w_head),
        .i_stall       (i_stall),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_msg_type    (o_msg_type),
        .o_payload_len (o_payload_len)
    );

    a_payload_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_PAYLOAD) |->
            (o_status == ST_OK && o_msg_type == 5'd0 && o_payload_len == 16'd0))
        else $error("payload item carries verdict fields");

    a_verdict_byte_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_VERDICT) |-> (o_out_byte == 8'd0))
        else $error("verdict item carries a data byte");

    a_ok_has_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_VERDICT && o_status == ST_OK) |->
            (o_msg_type >= 5'd1 && o_msg_type <= 5'd16))
        else $error("good frame verdict without a valid type");

    a_full_means_output_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("queue full while output register is empty");

endmodule

// ----- sim/crc_frame_deframer_checker_unit_tb.sv -----
`timescale 1ns / 1ps

module testbench;
    import cfdc_pkg::*;

    localparam int          HEADER_BYTES = 10;
    localparam int          MAGIC_BYTES  = 4;
    localparam int          FCS_BYTES    = 4;
    localparam logic [16:0] POS_LIMIT    = 17'h1FFFF;
    localparam logic [31:0] LEN_LIMIT    = 32'd65535;
    localparam logic [7:0]  TYPE_LO      = 8'd1;
    localparam logic [7:0]  TYPE_HI      = 8'd16;
    localparam logic [31:0] CRC_POLY_R   = 32'hEDB88320;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;
    localparam int          QUIET_LIMIT  = 2000;

    class deframer_scoreboard;
        logic [31:0] cfg_magic;
        logic [7:0]  cfg_version;
        logic [15:0] cfg_max_len;
        logic [16:0] rx_pos;
        logic [31:0] magic_word;
        logic [7:0]  version_byte;
        logic [7:0]  type_byte;
        logic [31:0] length_word;
        logic [31:0] crc_acc;
        logic [31:0] fcs_window;
        t_result     expected_items[$];
        int          mismatches;

        function new();
            cfg_magic   = 32'h0;
            cfg_version = 8'd1;
            cfg_max_len = 16'hFFFF;
            mismatches  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            rx_pos       = '0;
            magic_word   = '0;
            version_byte = '0;
            type_byte    = '0;
            length_word  = '0;
            crc_acc      = '1;
            fcs_window   = '0;
        endfunction

        function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
            logic [31:0] r;
            logic        fb;
            r = crc;
            for (int k = 0; k < 8; k++) begin
                fb = r[0] ^ b[k];
                r  = r >> 1;
                if (fb) begin
                    r = r ^ CRC_POLY_R;
                end
            end
            return r;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_MAGIC: begin
                    cfg_magic = data;
                end
                CFG_VERSION: begin
                    cfg_version = data[7:0];
                end
                CFG_MAX_PAYLOAD: begin
                    cfg_max_len = data[15:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void accept_byte(logic [7:0] b, logic last);
            logic [33:0] frame_end;
            logic        in_body;
            t_status     verdict;
            t_result     r;
            if (rx_pos < MAGIC_BYTES) begin
                magic_word = {b, magic_word[31:8]};
            end else if (rx_pos == MAGIC_BYTES) begin
                version_byte = b;
            end else if (rx_pos == MAGIC_BYTES + 1) begin
                type_byte = b;
            end else if (rx_pos < HEADER_BYTES) begin
                length_word = {b, length_word[31:8]};
            end
            fcs_window = {b, fcs_window[31:8]};
            frame_end  = 34'(HEADER_BYTES) + 34'(length_word);
            in_body    = (rx_pos >= HEADER_BYTES) && (34'(rx_pos) < frame_end);
            if (rx_pos >= MAGIC_BYTES && (rx_pos < HEADER_BYTES || in_body)) begin
                crc_acc = crc_step(crc_acc, b);
            end
            if (rx_pos != POS_LIMIT) begin
                rx_pos = rx_pos + 1'b1;
            end
            if (!last) begin
                if (in_body) begin
                    r.kind        = KIND_PAYLOAD;
                    r.out_byte    = b;
                    r.status      = ST_OK;
                    r.msg_type    = '0;
                    r.payload_len = '0;
                    expected_items.insert(expected_items.size(), r);
                end
                return;
            end
            if (rx_pos < HEADER_BYTES) begin
                verdict = ST_SHORT;
            end else if (magic_word != cfg_magic) begin
                verdict = ST_MAGIC;
            end else if (version_byte != cfg_version) begin
                verdict = ST_VERSION;
            end else if (type_byte < TYPE_LO || type_byte > TYPE_HI) begin
                verdict = ST_TYPE;
            end else if (length_word > {16'h0, cfg_max_len} || length_word > LEN_LIMIT) begin
                verdict = ST_LONG;
            end else if (34'(rx_pos) != frame_end + FCS_BYTES) begin
                verdict = ST_SIZE;
            end else if (~crc_acc != fcs_window) begin
                verdict = ST_CRC;
            end else begin
                verdict = ST_OK;
            end
            r.kind        = KIND_VERDICT;
            r.out_byte    = '0;
            r.status      = verdict;
            r.msg_type    = (type_byte >= TYPE_LO && type_byte <= TYPE_HI) ? type_byte[4:0] : '0;
            r.payload_len = (length_word > LEN_LIMIT) ? 16'hFFFF : length_word[15:0];
            expected_items.insert(expected_items.size(), r);
            clear_frame();
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches < 200) begin
                    $error("%s: expected %0h, got %0h", field, want, got);
                end
            end
        endfunction

        function void check_item(logic kind, logic [7:0] data, logic [2:0] status,
                                 logic [4:0] mtype, logic [15:0] plen);
            t_result want;
            if (expected_items.size() == 0) begin
                mismatches++;
                if (mismatches < 200) begin
                    $error("unexpected item: kind %0d byte %0h status %0d", kind, data, status);
                end
                return;
            end
            want = expected_items.pop_front();
            check_field("kind", want.kind, kind);
            check_field("out_byte", want.out_byte, data);
            check_field("status", want.status, status);
            check_field("msg_type", want.msg_type, mtype);
            check_field("payload_len", want.payload_len, plen);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_kind;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_status;
    logic [4:0]  o_msg_type;
    logic [15:0] o_payload_len;

    deframer_scoreboard sb = new();
    logic [7:0] frame_bytes[$];
    int         bytes_sent = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b1;
    int         quiet_cycles = 0;
    int         rx_mode = 0;
    int         rx_left = 0;

    crc_frame_deframer_checker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_msg_type    (o_msg_type),
        .o_payload_len (o_payload_len)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 200);
        end
        rx_left--;
        case (rx_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 7) == 0);
            2: i_stall <= 1'($urandom_range(0, 1));
            default: i_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_item(o_kind, o_out_byte, o_status, o_msg_type, o_payload_len);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("crc_frame_deframer_checker_unit regression: fail");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sb.accept_byte(b, last);
    endtask

    task automatic maybe_gap();
        int idle;
        if (burst_left == 0) begin
            idle       = gaps_on ? $urandom_range(0, 6) : 0;
            burst_left = $urandom_range(1, 24);
            if (idle > 0) begin
                i_valid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[k]) begin
            maybe_gap();
            send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
        end
        bytes_sent += frame_bytes.size();
    endtask

    // Wait until every expected item has come out, then let the pipeline settle.
    task automatic drain_results(input int settle);
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.expected_items.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] magic, input logic [31:0] ver,
                             input logic [31:0] max_len);
        logic [1:0]  idx_list[4];
        logic [31:0] data_list[4];
        idx_list  = '{CFG_MAGIC, CFG_VERSION, CFG_MAX_PAYLOAD, CFG_UNUSED};
        data_list = '{magic, ver, max_len, 32'($urandom)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= data_list[k];
            @(posedge i_clk);
            sb.set_register(idx_list[k], data_list[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Header, random body and a CRC over version through body, xored with crc_flip.
    function automatic void build_frame(input logic [31:0] magic, input logic [7:0] ver,
                                        input logic [7:0] typ, input logic [31:0] len_field,
                                        input int body, input logic [31:0] crc_flip);
        logic [31:0] crc;
        logic [31:0] fcs;
        frame_bytes.delete();
        for (int k = 0; k < 4; k++) frame_bytes.insert(frame_bytes.size(), magic[8*k +: 8]);
        frame_bytes.insert(frame_bytes.size(), ver);
        frame_bytes.insert(frame_bytes.size(), typ);
        for (int k = 0; k < 4; k++) frame_bytes.insert(frame_bytes.size(), len_field[8*k +: 8]);
        for (int k = 0; k < body; k++) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
        crc = '1;
        for (int k = MAGIC_BYTES; k < frame_bytes.size(); k++) begin
            crc = sb.crc_step(crc, frame_bytes[k]);
        end
        fcs = ~crc ^ crc_flip;
        for (int k = 0; k < 4; k++) frame_bytes.insert(frame_bytes.size(), fcs[8*k +: 8]);
    endfunction

    task automatic send_case(input logic [31:0] magic, input logic [7:0] ver,
                             input logic [7:0] typ, input logic [31:0] len_field,
                             input int body, input logic [31:0] crc_flip, input int keep);
        build_frame(magic, ver, typ, len_field, body, crc_flip);
        while (keep > 0 && frame_bytes.size() > keep) begin
            void'(frame_bytes.pop_back());
        end
        send_frame();
    endtask

    task automatic random_frame();
        int          pick;
        int          body;
        int          keep;
        logic [31:0] magic;
        logic [7:0]  ver;
        logic [7:0]  typ;
        logic [31:0] len_field;
        logic [31:0] flip;
        pick    = $urandom_range(0, 99);
        gaps_on = ($urandom_range(0, 3) != 0);
        magic   = sb.cfg_magic;
        ver     = sb.cfg_version;
        typ     = 8'($urandom_range(TYPE_LO, TYPE_HI));
        body    = $urandom_range(0, (sb.cfg_max_len < 16) ? int'(sb.cfg_max_len) : 16);
        len_field = body;
        flip    = '0;
        keep    = 0;
        if (pick < 55) begin
        end else if (pick < 61) begin
            magic = magic ^ (32'($urandom) | (32'h1 << $urandom_range(0, 31)));
        end else if (pick < 67) begin
            ver = ver ^ 8'($urandom_range(1, 255));
        end else if (pick < 73) begin
            typ = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(17, 255));
        end else if (pick < 79) begin
            len_field = ($urandom_range(0, 1) == 0) ? sb.cfg_max_len + $urandom_range(1, 40)
                                                    : 32'($urandom);
            body = $urandom_range(0, 12);
        end else if (pick < 86) begin
            case ($urandom_range(0, 2))
                0: body = body + $urandom_range(1, 4);
                1: len_field = len_field + $urandom_range(1, 4);
                default: keep = HEADER_BYTES + FCS_BYTES + body - $urandom_range(1, 3);
            endcase
        end else if (pick < 92) begin
            flip = 32'($urandom) | (32'h1 << $urandom_range(0, 31));
        end else if (pick < 96) begin
            keep = $urandom_range(1, HEADER_BYTES - 1);
        end else begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 30)) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
            send_frame();
            return;
        end
        send_case(magic, ver, typ, len_field, body, flip, keep);
    endtask

    task automatic run_random_phase(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            random_frame();
            if ($urandom_range(0, 24) == 0) begin
                drain_results(0);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_case(32'h0, 8'd1, 8'd1, 0, 0, 0, 0);
        send_case(32'h0, 8'd1, 8'd16, 3, 3, 0, 0);
        send_case(32'h0, 8'd1, 8'd5, 2, 2, 0, 1);
        send_case(32'h0, 8'd1, 8'd5, 2, 2, 0, 9);
        send_case(32'hFFFFFFFF, 8'd1, 8'd5, 1, 1, 0, 0);
        send_case(32'h0, 8'd0, 8'd5, 1, 1, 0, 0);
        send_case(32'h0, 8'hFF, 8'd5, 1, 1, 0, 0);
        send_case(32'h0, 8'd1, 8'd0, 1, 1, 0, 0);
        send_case(32'h0, 8'd1, 8'd17, 1, 1, 0, 0);
        send_case(32'h0, 8'd1, 8'hFF, 1, 1, 0, 0);
        send_case(32'h0, 8'd1, 8'd2, 32'hFFFFFFFF, 6, 0, 0);
        send_case(32'h0, 8'd1, 8'd2, 32'h00010000, 2, 0, 0);
        send_case(32'h0, 8'd1, 8'd2, 32'h0000FFFF, 2, 0, 0);
        send_case(32'h0, 8'd1, 8'd3, 5, 3, 0, 0);
        send_case(32'h0, 8'd1, 8'd3, 2, 6, 0, 0);
        // The final byte falls inside the body, so only the verdict comes out for it.
        send_case(32'h0, 8'd1, 8'd4, 8, 3, 0, HEADER_BYTES + 3);
        send_case(32'h0, 8'd1, 8'd4, 4, 4, 32'h00000001, 0);
        send_case(32'h0, 8'd1, 8'd4, 4, 4, 32'h80000000, 0);

        drain_results(6);
        configure(32'($urandom), 32'($urandom), {16'($urandom), 16'd40});
        run_random_phase(210);

        drain_results(6);
        configure(32'hFFFFFFFF, {24'($urandom), 8'hFF}, {16'($urandom), 16'h0000});
        run_random_phase(210);

        drain_results(6);
        configure(32'h0, {24'($urandom), 8'h00}, {16'($urandom), 16'hFFFF});
        run_random_phase(210);

        drain_results(6);
        configure(32'($urandom), 32'($urandom), 32'($urandom_range(1, 30)));
        run_random_phase(210);

        drain_results(12);
        if (sb.mismatches == 0) begin
            $display("crc_frame_deframer_checker_unit regression: pass");
        end else begin
            $display("crc_frame_deframer_checker_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- crc_frame_deframer_checker_unit.f -----
rtl/cfdc_pkg.sv
rtl/cfdc_front.sv
rtl/cfdc_queue.sv
rtl/cfdc_back.sv
rtl/crc_frame_deframer_checker_unit.sv
sim/crc_frame_deframer_checker_unit_tb.sv
